### src/bli_pkg.sv
// ----------------------------------------------------------------------------
// bli_pkg: shared definitions for the bounded list
// Sizes, command and status codes, and the control word that the list
// controller broadcasts along the row of storage cells.
// ----------------------------------------------------------------------------
package bli_pkg;

    // Built number of storage cells
    localparam int DEPTH  = 16;

    // Fixed field widths
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int POS_W  = 5;
    localparam int CAP_W  = 5;
    localparam int STAT_W = 2;

    // Derived widths
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_A  = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int CMP_W  = (CMP_A > CAP_W) ? CMP_A : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Commands
    localparam logic [CMD_W-1:0] CMD_APPEND    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ      = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;

    // Control word broadcast to every cell
    typedef struct packed {
        logic                     ins;
        logic                     del;
        logic [IDX_W-1:0]         pos;
        logic signed [DATA_W-1:0] elem;
    } cell_ctl_t;

endpackage

### src/bli_cell.sv
// ----------------------------------------------------------------------------
// bli_cell: one storage cell of the list
// Holds one entry. On an insert it takes its lower neighbour's entry (or the
// new element at the insert point); on a delete it takes its upper
// neighbour's entry. Drives its entry onto the read bus when addressed.
// ----------------------------------------------------------------------------
module bli_cell (
    input  logic                             aclk,
    input  bli_pkg::cell_ctl_t               ctl,
    input  logic [bli_pkg::IDX_W-1:0]        cell_idx,
    input  logic signed [bli_pkg::DATA_W-1:0] left_val,
    input  logic signed [bli_pkg::DATA_W-1:0] right_val,
    output logic signed [bli_pkg::DATA_W-1:0] value,
    output logic signed [bli_pkg::DATA_W-1:0] rd_val
);

    logic signed [bli_pkg::DATA_W-1:0] entry_reg;
    logic signed [bli_pkg::DATA_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins) begin
            if (cell_idx > ctl.pos) begin
                entry_next = left_val;
            end else if (cell_idx == ctl.pos) begin
                entry_next = ctl.elem;
            end
        end else if (ctl.del) begin
            // close the gap from above
            if (cell_idx >= ctl.pos) begin
                entry_next = right_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign value  = entry_reg;
    assign rd_val = (cell_idx == ctl.pos) ? entry_reg : '0;

endmodule

### src/bounded_list_insert_delete_top.sv
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_top: bounded ordered list with insert/delete
// Row of storage cells that shift in parallel under one controller.
// ----------------------------------------------------------------------------
// Every command (append, insert front, insert at position, delete at
// position, read) is carried out when its beat is accepted: the whole row
// of cells shifts in the cycle the beat is accepted, and the result is
// held in an output register. s_ready is high whenever that register is
// empty or being taken, so one beat per cycle is sustained while m_ready
// stays high. The capacity register may be written at any time the block
// is idle; values above the built depth act as the built depth. Rejected
// commands leave the list as it was.
module bounded_list_insert_delete_top (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [bli_pkg::CAP_W-1:0]         cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bli_pkg::CMD_W-1:0]         s_command,
    input  logic signed [bli_pkg::DATA_W-1:0] s_element,
    input  logic [bli_pkg::POS_W-1:0]         s_position,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [bli_pkg::STAT_W-1:0]        m_status,
    output logic [bli_pkg::CNT_W-1:0]         m_count,
    output logic signed [bli_pkg::DATA_W-1:0] m_read_value
);

    localparam int DEPTH  = bli_pkg::DEPTH;
    localparam int DATA_W = bli_pkg::DATA_W;
    localparam int CNT_W  = bli_pkg::CNT_W;
    localparam int CMP_W  = bli_pkg::CMP_W;
    localparam int IDX_W  = bli_pkg::IDX_W;

    logic [bli_pkg::CAP_W-1:0]  cap_reg;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       m_valid_reg;
    logic [bli_pkg::STAT_W-1:0] status_reg;
    logic [bli_pkg::STAT_W-1:0] status_next;
    logic [CNT_W-1:0]           m_count_reg;
    logic signed [DATA_W-1:0]   rd_reg;
    logic signed [DATA_W-1:0]   rd_next;

    logic                       accept;
    logic [CMP_W-1:0]           cnt_ext;
    logic [CMP_W-1:0]           pos_ext;
    logic [CMP_W-1:0]           cap_ext;
    logic [CMP_W-1:0]           eff_cap;
    logic                       full;
    logic                       do_ins;
    logic                       do_del;
    logic                       do_read;
    logic [IDX_W-1:0]           ins_pos;
    logic signed [DATA_W-1:0]   rd_or;

    bli_pkg::cell_ctl_t         ctl;

    logic signed [DATA_W-1:0]   cell_val [DEPTH];
    logic signed [DATA_W-1:0]   cell_rd  [DEPTH];

    assign accept  = s_valid && s_ready;
    assign s_ready = !m_valid_reg || m_ready;

    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(s_position);
    assign cap_ext = CMP_W'(cap_reg);
    assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign full    = cnt_ext >= eff_cap;

    // Command decode
    always_comb begin
        status_next = bli_pkg::ST_OK;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_read     = 1'b0;
        ins_pos     = s_position[IDX_W-1:0];
        unique case (s_command)
            bli_pkg::CMD_APPEND: begin
                ins_pos = count_reg[IDX_W-1:0];
                if (full) begin
                    status_next = bli_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            bli_pkg::CMD_INS_FRONT: begin
                ins_pos = '0;
                if (full) begin
                    status_next = bli_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            bli_pkg::CMD_INS_POS: begin
                if (full) begin
                    status_next = bli_pkg::ST_FULL;
                end else if (pos_ext > cnt_ext) begin
                    status_next = bli_pkg::ST_BADPOS;
                end else begin
                    do_ins = 1'b1;
                end
            end
            bli_pkg::CMD_DEL_POS: begin
                if (pos_ext >= cnt_ext) begin
                    status_next = bli_pkg::ST_BADPOS;
                end else begin
                    do_del = 1'b1;
                end
            end
            bli_pkg::CMD_READ: begin
                if (pos_ext >= cnt_ext) begin
                    status_next = bli_pkg::ST_BADPOS;
                end else begin
                    do_read = 1'b1;
                end
            end
            default: begin
                status_next = bli_pkg::ST_BADPOS;
            end
        endcase
    end

    always_comb begin
        ctl.ins  = accept && do_ins;
        ctl.del  = accept && do_del;
        ctl.pos  = ins_pos;
        ctl.elem = s_element;
    end

    always_comb begin
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Row of cells; the ends feed back their own entry
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [DATA_W-1:0] left_v;
        logic signed [DATA_W-1:0] right_v;

        if (g == 0) begin : g_first
            assign left_v = cell_val[g];
        end else begin : g_mid_l
            assign left_v = cell_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_v = cell_val[g];
        end else begin : g_mid_r
            assign right_v = cell_val[g+1];
        end

        bli_cell u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .cell_idx  (IDX_W'(g)),
            .left_val  (left_v),
            .right_val (right_v),
            .value     (cell_val[g]),
            .rd_val    (cell_rd[g])
        );
    end

    always_comb begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or = rd_or | cell_rd[i];
        end
        rd_next = do_read ? rd_or : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg     <= bli_pkg::CAP_RESET;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            count_reg <= count_next;
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on every accepted beat
    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status_next;
            m_count_reg <= count_next;
            rd_reg      <= rd_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = status_reg;
    assign m_count      = m_count_reg;
    assign m_read_value = rd_reg;

endmodule

### tb/sv/bounded_list_insert_delete_top_test.sv
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_top_test: self-checking bench for the bounded list
// Drives list commands through the input channel under random back-pressure,
// keeps a shadow copy of the list and its capacity, and checks every result
// beat field by field against the shadow's answer. Walks several capacity
// settings, including zero, below the current count and above the depth.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH  = bli_pkg::DEPTH;
    localparam int DATA_W = bli_pkg::DATA_W;
    localparam int CMD_W  = bli_pkg::CMD_W;
    localparam int POS_W  = bli_pkg::POS_W;
    localparam int CAP_W  = bli_pkg::CAP_W;
    localparam int STAT_W = bli_pkg::STAT_W;
    localparam int CNT_W  = bli_pkg::CNT_W;

    typedef struct {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] elem;
        logic [POS_W-1:0]         pos;
    } list_cmd_t;

    typedef struct {
        logic [STAT_W-1:0]        status;
        logic [CNT_W-1:0]         count;
        logic signed [DATA_W-1:0] read_value;
    } list_result_t;

    logic                       aclk;
    logic                       aresetn;
    logic                       cfg_wr_en;
    logic [CAP_W-1:0]           cfg_wr_data;
    logic                       s_valid;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_command;
    logic signed [DATA_W-1:0]   s_element;
    logic [POS_W-1:0]           s_position;
    logic                       m_valid;
    logic                       m_ready;
    logic [STAT_W-1:0]          m_status;
    logic [CNT_W-1:0]           m_count;
    logic signed [DATA_W-1:0]   m_read_value;

    list_cmd_t                  command_queue[$];
    list_result_t               pending_results[$];
    list_cmd_t                  next_cmd;
    list_result_t               got_result;
    list_result_t               want_result;
    logic                       cmd_beat_taken;
    logic                       steady;
    int                         mismatches;

    // Shadow of the list held by the block
    logic signed [DATA_W-1:0]   model_words[DEPTH];
    int                         model_len;
    logic [CAP_W-1:0]           model_cap;

    bounded_list_insert_delete_top DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_command    (s_command),
        .s_element    (s_element),
        .s_position   (s_position),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_count      (m_count),
        .m_read_value (m_read_value)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void shift_in(input int p, input logic signed [DATA_W-1:0] v);
        int i;
        for (i = model_len; i > p; i--)
            model_words[i] = model_words[i-1];
        model_words[p] = v;
        model_len++;
    endfunction

    function automatic list_result_t apply_command(input list_cmd_t c);
        list_result_t r;
        int           lim;
        logic         full;
        int           i;
        lim          = (model_cap > DEPTH) ? DEPTH : int'(model_cap);
        full         = (model_len >= lim);
        r.status     = bli_pkg::ST_OK;
        r.read_value = '0;
        case (c.cmd)
            bli_pkg::CMD_APPEND: begin
                if (full) r.status = bli_pkg::ST_FULL;
                else shift_in(model_len, c.elem);
            end
            bli_pkg::CMD_INS_FRONT: begin
                if (full) r.status = bli_pkg::ST_FULL;
                else shift_in(0, c.elem);
            end
            bli_pkg::CMD_INS_POS: begin
                // full takes precedence over a bad position
                if (full) r.status = bli_pkg::ST_FULL;
                else if (int'(c.pos) > model_len) r.status = bli_pkg::ST_BADPOS;
                else shift_in(int'(c.pos), c.elem);
            end
            bli_pkg::CMD_DEL_POS: begin
                if (int'(c.pos) >= model_len) begin
                    r.status = bli_pkg::ST_BADPOS;
                end else begin
                    for (i = int'(c.pos); i + 1 < model_len; i++)
                        model_words[i] = model_words[i+1];
                    model_len--;
                end
            end
            bli_pkg::CMD_READ: begin
                if (int'(c.pos) >= model_len) r.status = bli_pkg::ST_BADPOS;
                else r.read_value = model_words[c.pos];
            end
            default: r.status = bli_pkg::ST_BADPOS;
        endcase
        r.count = CNT_W'(model_len);
        return r;
    endfunction

    // Driver: present the next command, hold it until the beat is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || cmd_beat_taken) begin
            if (command_queue.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
                next_cmd   = command_queue.pop_front();
                s_valid    <= 1'b1;
                s_command  <= next_cmd.cmd;
                s_element  <= next_cmd.elem;
                s_position <= next_cmd.pos;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= steady || ($urandom_range(99) >= 7);
    end

    // Monitor: check result beats first, then predict for the command beat
    always @(posedge aclk) begin
        cmd_beat_taken = 1'b0;
        if (!aresetn) begin
            model_len = 0;
            model_cap = bli_pkg::CAP_RESET;
        end else begin
            if (cfg_wr_en)
                model_cap = cfg_wr_data;
            if (m_valid && m_ready) begin
                got_result.status     = m_status;
                got_result.count      = m_count;
                got_result.read_value = m_read_value;
                if (pending_results.size() == 0) begin
                    $error("result beat with no command outstanding");
                    mismatches++;
                end else begin
                    want_result = pending_results.pop_front();
                    if (got_result.status !== want_result.status) begin
                        $error("status: expected %0d, got %0d",
                               want_result.status, got_result.status);
                        mismatches++;
                    end
                    if (got_result.count !== want_result.count) begin
                        $error("count: expected %0d, got %0d",
                               want_result.count, got_result.count);
                        mismatches++;
                    end
                    if (got_result.read_value !== want_result.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want_result.read_value, got_result.read_value);
                        mismatches++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                cmd_beat_taken = 1'b1;
                pending_results.push_back(apply_command('{s_command, s_element, s_position}));
            end
        end
    end

    task automatic queue_cmd(input logic [CMD_W-1:0] c, input logic signed [DATA_W-1:0] e,
                             input logic [POS_W-1:0] p);
        command_queue.push_back('{c, e, p});
    endtask

    task automatic drain;
        while (command_queue.size() != 0 || s_valid || pending_results.size() != 0)
            @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Stimulus
    initial begin
        logic [CAP_W-1:0] phase_caps[6];
        int               phase;
        int               n;
        int               grow_pct;
        int               roll;
        int               pos_top;
        list_cmd_t        c;

        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_command   = '0;
        s_element   = '0;
        s_position  = '0;
        m_ready     = 1'b0;
        steady      = 1'b0;
        mismatches  = 0;
        cmd_beat_taken = 1'b0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Capacity above the depth saturates to the depth
        set_capacity(5'd31);

        // Operations on an empty list
        queue_cmd(bli_pkg::CMD_READ,      32'sd0, 5'd0);
        queue_cmd(bli_pkg::CMD_DEL_POS,   32'sd0, 5'd0);
        queue_cmd(bli_pkg::CMD_INS_POS,   32'sd5, 5'd1);
        // Build up with the element extremes
        queue_cmd(bli_pkg::CMD_APPEND,    32'h7fffffff, 5'd0);
        queue_cmd(bli_pkg::CMD_INS_FRONT, 32'h80000000, 5'd31);
        queue_cmd(bli_pkg::CMD_INS_POS,   -32'sd1, 5'd1);
        queue_cmd(bli_pkg::CMD_INS_POS,   32'sd0, 5'd3);
        queue_cmd(bli_pkg::CMD_INS_POS,   32'sd7, 5'd31);
        queue_cmd(bli_pkg::CMD_READ,      32'sd0, 5'd0);
        queue_cmd(bli_pkg::CMD_READ,      32'sd0, 5'd3);
        queue_cmd(bli_pkg::CMD_READ,      32'sd0, 5'd4);
        queue_cmd(bli_pkg::CMD_READ,      32'sd0, 5'd31);
        queue_cmd(bli_pkg::CMD_DEL_POS,   32'sd0, 5'd31);
        queue_cmd(bli_pkg::CMD_DEL_POS,   32'sd0, 5'd1);
        // Undefined commands
        queue_cmd(bli_pkg::CMD_READ + 3'd1, 32'sd1, 5'd0);
        queue_cmd(bli_pkg::CMD_READ + 3'd2, 32'sd2, 5'd1);
        queue_cmd(bli_pkg::CMD_READ + 3'd3, -32'sd1, 5'd31);
        drain();

        // Capacity dropped below the count: inserts refuse, delete and read work
        set_capacity(5'd2);
        queue_cmd(bli_pkg::CMD_APPEND,    32'sd11, 5'd0);
        queue_cmd(bli_pkg::CMD_INS_FRONT, 32'sd12, 5'd0);
        queue_cmd(bli_pkg::CMD_INS_POS,   32'sd13, 5'd31);
        queue_cmd(bli_pkg::CMD_READ,      32'sd0, 5'd2);
        queue_cmd(bli_pkg::CMD_DEL_POS,   32'sd0, 5'd0);
        queue_cmd(bli_pkg::CMD_APPEND,    32'sd14, 5'd0);
        queue_cmd(bli_pkg::CMD_DEL_POS,   32'sd0, 5'd1);
        queue_cmd(bli_pkg::CMD_INS_POS,   32'sd15, 5'd1);
        drain();

        set_capacity(5'd0);
        queue_cmd(bli_pkg::CMD_APPEND,    32'sd16, 5'd0);
        queue_cmd(bli_pkg::CMD_READ,      32'sd0, 5'd1);
        drain();

        // Random phases under different capacities
        phase_caps[0] = 5'd16;
        phase_caps[1] = 5'd1;
        phase_caps[2] = 5'd31;
        phase_caps[3] = 5'd0;
        phase_caps[4] = 5'd5;
        phase_caps[5] = CAP_W'($urandom_range(16));
        for (phase = 0; phase < 6; phase++) begin
            set_capacity(phase_caps[phase]);
            // one phase runs with no gaps or stalls on either side
            steady   = (phase == 2);
            grow_pct = (phase % 2 == 0) ? 65 : 35;
            pos_top  = (phase_caps[phase] > DEPTH) ? DEPTH : int'(phase_caps[phase]);
            for (n = 0; n < 90; n++) begin
                c.elem = $urandom;
                roll   = $urandom_range(99);
                if (roll < 15) c.pos = POS_W'($urandom_range(31));
                else if (roll < 40) c.pos = POS_W'($urandom_range(3));
                else c.pos = POS_W'($urandom_range(pos_top));
                roll = $urandom_range(99);
                if (roll < 5) begin
                    c.cmd = CMD_W'($urandom_range(7, bli_pkg::CMD_READ + 1));
                end else if (roll < 5 + grow_pct) begin
                    case ($urandom_range(2))
                        0:       c.cmd = bli_pkg::CMD_APPEND;
                        1:       c.cmd = bli_pkg::CMD_INS_FRONT;
                        default: c.cmd = bli_pkg::CMD_INS_POS;
                    endcase
                end else begin
                    c.cmd = $urandom_range(1) ? bli_pkg::CMD_DEL_POS : bli_pkg::CMD_READ;
                end
                command_queue.push_back(c);
            end
            drain();
        end
        steady = 1'b0;

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
